>>> hdl/mbg_pkg.sv
// ============================================================================
// mbg_pkg
// Shared types, constants and helpers for the backtracking maze generator.
// ============================================================================
`default_nettype none

package mbg_pkg;

   localparam int MAX_COLUMNS = 64;
   localparam int MAX_ROWS    = 64;
   localparam int CELL_SLOTS  = 4096;
   localparam int CELL_W      = $clog2(CELL_SLOTS);
   localparam int DEPTH_W     = CELL_W + 1;
   localparam int DIM_W       = 7;
   localparam int WORD_W      = 5;   // {visited, walls[3:0]}

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_STEP  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [2:0] ST_CARVED      = 3'd0;
   localparam logic [2:0] ST_BACKTRACKED = 3'd1;
   localparam logic [2:0] ST_FINISHED    = 3'd2;
   localparam logic [2:0] ST_READ        = 3'd3;
   localparam logic [2:0] ST_STARTED     = 3'd4;

   localparam logic CSR_COLUMNS = 1'b0;
   localparam logic CSR_ROWS    = 1'b1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] random_value;
      logic [11:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [11:0] from_cell;
      logic [11:0] to_cell;
      logic [3:0]  cell_walls;
      logic        done_res;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       clr_en;
      logic       clr_mark;
      logic       rd_idx;
      logic       cur_load;
      logic       nb_rd;
      logic       pick;
      logic       wr_cur;
      logic       wr_nxt;
      logic       pop;
      logic       rsp_load;
      logic [2:0] rsp_status;
   } ctl_cmd_type;

   typedef struct packed {
      logic depth_zero;
      logic clr_last;
      logic div_done;
      logic nb_last;
      logic carve_ok;
   } dp_status_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // 16-bit value modulo 3 by folding base-4 digits
   function automatic logic [1:0] mod3_16(input logic [15:0] v);
      logic [4:0] s;
      logic [2:0] t;
      logic [2:0] u;
      logic [1:0] r;
      s = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6])
        + 5'(v[9:8]) + 5'(v[11:10]) + 5'(v[13:12]) + 5'(v[15:14]);
      t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
      u = 3'(t[1:0]) + 3'(t[2]);
      if (u >= 3'd3) begin
         r = 2'(u - 3'd3);
      end else begin
         r = u[1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hdl/mbg_ram.sv
// ============================================================================
// mbg_ram
// Generic single write port RAM with one registered read port.
// ============================================================================
`default_nettype none

module mbg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

>>> hdl/mbg_div.sv
// ============================================================================
// mbg_div
// Restoring divider, one quotient bit per cycle: cell index by column count.
// ============================================================================
`default_nettype none

module mbg_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [mbg_pkg::CELL_W-1:0] dividend,
   input  wire logic [mbg_pkg::DIM_W-1:0]  divisor,
   output logic      [mbg_pkg::CELL_W-1:0] quotient,
   output logic      [mbg_pkg::DIM_W-1:0]  remainder,
   output logic                           done
);

   import mbg_pkg::*;

   localparam int CNT_W = $clog2(CELL_W);

   logic [CELL_W-1:0] quo_ff, quo_in;
   logic [DIM_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [DIM_W-1:0]  trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DIM_W-2:0], quo_ff[CELL_W-1]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= divisor) begin
            rem_in = trial - divisor;
            quo_in = {quo_ff[CELL_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[CELL_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(CELL_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

`default_nettype wire

>>> hdl/mbg_ctrl.sv
// ============================================================================
// mbg_ctrl
// Command sequencer: clear sweeps, step pass, wall read and responses.
// ============================================================================
`default_nettype none

module mbg_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [1:0]            req_cmd,
   input  wire mbg_pkg::dp_status_type status,
   output mbg_pkg::ctl_cmd_type       ctl,
   output logic                       busy
);

   import mbg_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE      = 14'b00000000000001,
      S_CLR_RST   = 14'b00000000000010,
      S_CLR_START = 14'b00000000000100,
      S_CELL_RD   = 14'b00000000001000,
      S_RD_WAIT   = 14'b00000000010000,
      S_STK_RD    = 14'b00000000100000,
      S_CUR_LD    = 14'b00000001000000,
      S_DIV_WAIT  = 14'b00000010000000,
      S_NB_RD     = 14'b00000100000000,
      S_NB_WAIT   = 14'b00001000000000,
      S_PICK      = 14'b00010000000000,
      S_WR_CUR    = 14'b00100000000000,
      S_WR_NXT    = 14'b01000000000000,
      S_POP       = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               unique case (req_cmd)
                  CMD_START: state_in = S_CLR_START;
                  CMD_STEP: begin
                     if (status.depth_zero) begin
                        ctl.rsp_load   = 1'b1;
                        ctl.rsp_status = ST_FINISHED;
                     end else begin
                        state_in = S_STK_RD;
                     end
                  end
                  CMD_READ: state_in = S_CELL_RD;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_CLR_RST: begin
            ctl.clr_en = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_CLR_START: begin
            ctl.clr_en   = 1'b1;
            ctl.clr_mark = 1'b1;
            if (status.clr_last) begin
               ctl.rsp_load   = 1'b1;
               ctl.rsp_status = ST_STARTED;
               state_in       = S_IDLE;
            end
         end
         S_CELL_RD: begin
            ctl.rd_idx = 1'b1;
            state_in   = S_RD_WAIT;
         end
         S_RD_WAIT: begin
            ctl.rsp_load   = 1'b1;
            ctl.rsp_status = ST_READ;
            state_in       = S_IDLE;
         end
         S_STK_RD: state_in = S_CUR_LD;
         S_CUR_LD: begin
            ctl.cur_load = 1'b1;
            state_in     = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = S_NB_RD;
            end
         end
         S_NB_RD: begin
            ctl.nb_rd = 1'b1;
            if (status.nb_last) begin
               state_in = S_NB_WAIT;
            end
         end
         S_NB_WAIT: state_in = S_PICK;
         S_PICK: begin
            ctl.pick = 1'b1;
            state_in = status.carve_ok ? S_WR_CUR : S_POP;
         end
         S_WR_CUR: begin
            ctl.wr_cur = 1'b1;
            state_in   = S_WR_NXT;
         end
         S_WR_NXT: begin
            ctl.wr_nxt     = 1'b1;
            ctl.rsp_load   = 1'b1;
            ctl.rsp_status = ST_CARVED;
            state_in       = S_IDLE;
         end
         S_POP: begin
            ctl.pop        = 1'b1;
            ctl.rsp_load   = 1'b1;
            ctl.rsp_status = ST_BACKTRACKED;
            state_in       = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR_RST;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

>>> hdl/mbg_dp.sv
// ============================================================================
// mbg_dp
// Datapath: cell and stack RAMs, divider, neighbour scan, pick and response.
// ============================================================================
`default_nettype none

module mbg_dp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mbg_pkg::req_type      req_payload,
   input  wire mbg_pkg::ctl_cmd_type  ctl,
   input  wire logic [mbg_pkg::DIM_W-1:0] cols,
   input  wire logic [mbg_pkg::DIM_W-1:0] rows,
   output mbg_pkg::dp_status_type     status,
   output mbg_pkg::rsp_type           rsp_payload,
   output logic                       rsp_strobe
);

   import mbg_pkg::*;

   logic [15:0]        rnd_ff;
   logic [CELL_W-1:0]  idx_ff;
   logic [CELL_W-1:0]  cur_ff;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [CELL_W-1:0]  clr_addr_ff;
   logic [2:0]         rd_sel_ff, cap_sel_ff;
   logic               rdv_ff;
   logic [WORD_W-1:0]  cur_word_ff;
   logic [3:0]         nb_vis_ff;
   logic [3:0]         nb_walls_ff [4];
   logic [1:0]         dir_ff;
   logic [CELL_W-1:0]  nxt_ff;
   logic [3:0]         nxt_walls_ff;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_strobe_ff;

   logic [CELL_W-1:0]  quo;
   logic [DIM_W-1:0]   rem;
   logic               div_done;

   logic               cell_we;
   logic [CELL_W-1:0]  cell_waddr, cell_raddr;
   logic [WORD_W-1:0]  cell_wdata, cell_rdata;
   logic               stk_we;
   logic [CELL_W-1:0]  stk_waddr, stk_wdata, stk_raddr, stk_rdata;

   logic [CELL_W-1:0]  cols_c, top_a, right_a, bottom_a, left_a, sel_a, pick_a;
   logic               in_grid;
   logic [3:0]         ok, avail;
   logic [2:0]         n_avail;
   logic [1:0]         k_sel, pick_dir, cnt;
   logic               found, carve_ok;
   logic [3:0]         dir_mask, opp_mask;

   mbg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (ctl.cur_load),
      .dividend  (stk_rdata),
      .divisor   (cols),
      .quotient  (quo),
      .remainder (rem),
      .done      (div_done)
   );

   mbg_ram #(.WIDTH(WORD_W), .DEPTH(CELL_SLOTS)) u_cell_ram (
      .clock (clock),
      .we    (cell_we),
      .waddr (cell_waddr),
      .wdata (cell_wdata),
      .raddr (cell_raddr),
      .rdata (cell_rdata)
   );

   mbg_ram #(.WIDTH(CELL_W), .DEPTH(CELL_SLOTS)) u_stack_ram (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   // neighbour geometry of the current cell
   always_comb begin
      cols_c   = CELL_W'(cols);
      top_a    = cur_ff - cols_c;
      right_a  = cur_ff + CELL_W'(1);
      bottom_a = cur_ff + cols_c;
      left_a   = cur_ff - CELL_W'(1);
      in_grid  = quo < CELL_W'(rows);
      ok[0]    = in_grid && (quo != '0);
      ok[1]    = in_grid && ((DIM_W'(rem) + DIM_W'(1)) < cols)
                 && ((DEPTH_W'(cur_ff) + DEPTH_W'(1)) < DEPTH_W'(CELL_SLOTS));
      ok[2]    = in_grid && ((DEPTH_W'(quo) + DEPTH_W'(1)) < DEPTH_W'(rows))
                 && ((DEPTH_W'(cur_ff) + DEPTH_W'(cols)) < DEPTH_W'(CELL_SLOTS));
      ok[3]    = in_grid && (rem != '0);
   end

   always_comb begin
      unique case (rd_sel_ff)
         3'd1:    sel_a = top_a;
         3'd2:    sel_a = right_a;
         3'd3:    sel_a = bottom_a;
         3'd4:    sel_a = left_a;
         default: sel_a = cur_ff;
      endcase
   end

   // choose among free neighbours
   always_comb begin
      avail   = ok & ~nb_vis_ff;
      n_avail = 3'(avail[0]) + 3'(avail[1]) + 3'(avail[2]) + 3'(avail[3]);
      unique case (n_avail)
         3'd2:    k_sel = {1'b0, rnd_ff[0]};
         3'd3:    k_sel = mod3_16(rnd_ff);
         3'd4:    k_sel = rnd_ff[1:0];
         default: k_sel = 2'd0;
      endcase
      pick_dir = 2'd0;
      cnt      = 2'd0;
      found    = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (avail[i] && !found) begin
            if (cnt == k_sel) begin
               pick_dir = 2'(i);
               found    = 1'b1;
            end else begin
               cnt = cnt + 2'd1;
            end
         end
      end
      unique case (pick_dir)
         2'd0: pick_a = top_a;
         2'd1: pick_a = right_a;
         2'd2: pick_a = bottom_a;
         2'd3: pick_a = left_a;
         default: pick_a = top_a;
      endcase
      carve_ok = (avail != '0) && !depth_ff[DEPTH_W-1];
      dir_mask = 4'b0001 << dir_ff;
      opp_mask = 4'b0001 << (dir_ff + 2'd2);
   end

   // memory ports
   always_comb begin
      cell_we    = ctl.clr_en || ctl.wr_cur || ctl.wr_nxt;
      cell_waddr = nxt_ff;
      cell_wdata = {1'b1, nxt_walls_ff & ~opp_mask};
      if (ctl.clr_en) begin
         cell_waddr = clr_addr_ff;
         cell_wdata = (ctl.clr_mark && clr_addr_ff == '0) ? 5'b11111 : 5'b01111;
      end else if (ctl.wr_cur) begin
         cell_waddr = cur_ff;
         cell_wdata = {cur_word_ff[4], cur_word_ff[3:0] & ~dir_mask};
      end
      cell_raddr = ctl.rd_idx ? idx_ff : sel_a;
      stk_we     = (ctl.clr_en && ctl.clr_mark) || ctl.wr_cur;
      stk_waddr  = ctl.wr_cur ? depth_ff[CELL_W-1:0] : '0;
      stk_wdata  = ctl.wr_cur ? nxt_ff : '0;
      stk_raddr  = CELL_W'(depth_ff - DEPTH_W'(1));
   end

   always_comb begin
      depth_in = depth_ff;
      if (ctl.clr_en && ctl.clr_mark && status.clr_last) begin
         depth_in = DEPTH_W'(1);
      end else if (ctl.wr_nxt) begin
         depth_in = depth_ff + DEPTH_W'(1);
      end else if (ctl.pop) begin
         depth_in = depth_ff - DEPTH_W'(1);
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (ctl.rsp_load) begin
         rsp_in = '0;
         unique case (ctl.rsp_status)
            ST_CARVED: begin
               rsp_in.status    = ST_CARVED;
               rsp_in.from_cell = cur_ff;
               rsp_in.to_cell   = nxt_ff;
            end
            ST_BACKTRACKED: begin
               rsp_in.status    = ST_BACKTRACKED;
               rsp_in.from_cell = cur_ff;
               rsp_in.done_res  = (depth_ff == DEPTH_W'(1));
            end
            ST_FINISHED: begin
               rsp_in.status   = ST_FINISHED;
               rsp_in.done_res = 1'b1;
            end
            ST_READ: begin
               rsp_in.status     = ST_READ;
               rsp_in.from_cell  = idx_ff;
               rsp_in.cell_walls = cell_rdata[3:0];
               rsp_in.done_res   = (depth_ff == '0);
            end
            default: rsp_in.status = ST_STARTED;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff      <= '0;
         clr_addr_ff   <= '0;
         rd_sel_ff     <= '0;
         rdv_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         depth_ff      <= depth_in;
         rsp_strobe_ff <= ctl.rsp_load;
         rdv_ff        <= ctl.nb_rd;
         if (ctl.clr_en) begin
            clr_addr_ff <= clr_addr_ff + CELL_W'(1);
         end
         if (ctl.cur_load) begin
            rd_sel_ff <= '0;
         end else if (ctl.nb_rd) begin
            rd_sel_ff <= rd_sel_ff + 3'd1;
         end
      end
      cap_sel_ff <= rd_sel_ff;
      if (ctl.load) begin
         rnd_ff <= req_payload.random_value;
         idx_ff <= req_payload.cell_index;
      end
      if (ctl.cur_load) begin
         cur_ff <= stk_rdata;
      end
      if (rdv_ff) begin
         unique case (cap_sel_ff)
            3'd1: begin
               nb_vis_ff[0]   <= cell_rdata[4];
               nb_walls_ff[0] <= cell_rdata[3:0];
            end
            3'd2: begin
               nb_vis_ff[1]   <= cell_rdata[4];
               nb_walls_ff[1] <= cell_rdata[3:0];
            end
            3'd3: begin
               nb_vis_ff[2]   <= cell_rdata[4];
               nb_walls_ff[2] <= cell_rdata[3:0];
            end
            3'd4: begin
               nb_vis_ff[3]   <= cell_rdata[4];
               nb_walls_ff[3] <= cell_rdata[3:0];
            end
            default: cur_word_ff <= cell_rdata;
         endcase
      end
      if (ctl.pick) begin
         dir_ff       <= pick_dir;
         nxt_ff       <= pick_a;
         nxt_walls_ff <= nb_walls_ff[pick_dir];
      end
      rsp_ff <= rsp_in;
   end

   assign status.depth_zero = (depth_ff == '0);
   assign status.clr_last   = (clr_addr_ff == '1);
   assign status.div_done   = div_done;
   assign status.nb_last    = (rd_sel_ff == 3'd4);
   assign status.carve_ok   = carve_ok;
   assign rsp_payload       = rsp_ff;
   assign rsp_strobe        = rsp_strobe_ff;

endmodule

`default_nettype wire

>>> hdl/maze_backtracker_generator_top.sv
// ============================================================================
// maze_backtracker_generator_top
// Depth-first maze generator with explicit stack, one command at a time.
// ============================================================================
// Step: its busy time, carving or backtracking, is set by the bit-serial
//   cell/column divider and five sequential reads of the single cell RAM port.
// Start: all 4096 cell RAM entries are cleared, one cell RAM entry per cycle.
// Step on an empty stack and ignored commands leave busy low.
// Result strobe in the cycle after the last busy cycle; the receiver cannot stall.
// After reset the cell RAM is swept with busy high.
`default_nettype none

module maze_backtracker_generator_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire mbg_pkg::req_type req_payload,
   output logic                  rsp_strobe,
   output mbg_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic             csr_index,
   input  wire logic [6:0]       csr_data
);

   import mbg_pkg::*;

   logic [DIM_W-1:0] cols_ff, rows_ff;
   logic [DIM_W-1:0] cols_eff, rows_eff;
   ctl_cmd_type      ctl;
   dp_status_type    dp_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= DIM_W'(11);
         rows_ff <= DIM_W'(8);
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_COLUMNS) begin
            cols_ff <= csr_data;
         end else begin
            rows_ff <= csr_data;
         end
      end
   end

   assign cols_eff = clamp_dim(cols_ff, DIM_W'(MAX_COLUMNS));
   assign rows_eff = clamp_dim(rows_ff, DIM_W'(MAX_ROWS));

   mbg_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_payload.cmd),
      .status  (dp_status),
      .ctl     (ctl),
      .busy    (busy)
   );

   mbg_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .ctl         (ctl),
      .cols        (cols_eff),
      .rows        (rows_eff),
      .status      (dp_status),
      .rsp_payload (rsp_payload),
      .rsp_strobe  (rsp_strobe)
   );

   a_step_empty: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.cmd == CMD_STEP && dp_status.depth_zero)
      |=> (rsp_strobe && rsp_payload.status == ST_FINISHED && rsp_payload.done_res))
      else $error("step on empty stack did not finish");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.cmd == CMD_START) |=> busy)
      else $error("start command did not begin clear sweep");

   a_carve_distinct: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.status == ST_CARVED)
      |-> (rsp_payload.from_cell != rsp_payload.to_cell && !rsp_payload.done_res))
      else $error("carve transaction inconsistent");

   a_wr_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.clr_en, ctl.wr_cur, ctl.wr_nxt}))
      else $error("cell RAM write conflict");

endmodule

`default_nettype wire

>>> dv/maze_backtracker_generator_top_test.sv
// ----------------------------------------------------------------------------
// maze_backtracker_generator_top_test
// Self-checking bench for the backtracking maze generator. A predictor keeps
// its own visited map, walls, path stack and grid size, and every result
// transaction is compared field by field in order. Directed tests cover the
// corner cases, then random phases at several grid sizes carve with mixed commands.
// ----------------------------------------------------------------------------
`default_nettype none

module maze_backtracker_generator_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mbg_pkg::*;

   localparam logic [1:0] CMD_IGNORED = 2'd3;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   req_type       req_payload = '0;
   logic          rsp_strobe;
   rsp_type       rsp_payload;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic          csr_index = CSR_COLUMNS;
   logic [6:0]    csr_data = '0;

   maze_backtracker_generator_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // predictor state
   bit          cell_visited [CELL_SLOTS];
   logic [3:0]  cell_walls [CELL_SLOTS] = '{default: 4'hF};
   logic [11:0] path_cells [CELL_SLOTS];
   int unsigned path_depth;
   logic [6:0]  columns_reg = 7'd11;
   logic [6:0]  rows_reg = 7'd8;

   rsp_type     expected_rsps[$];
   int          fail_count;
   int          items_sent;
   int          status_seen [8];
   bit          no_idle;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic int unsigned used_dim(input logic [6:0] v, input int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // returns 1 when the command gives a result
   function automatic bit predict_command(input req_type r, output rsp_type e);
      int unsigned cols, rows, cur, x, y, n, k, nxt, c;
      int unsigned cand [4];
      int unsigned dirn [4];
      e = '0;
      cols = used_dim(columns_reg, MAX_COLUMNS);
      rows = used_dim(rows_reg, MAX_ROWS);
      n = 0;
      case (r.cmd)
         CMD_START: begin
            foreach (cell_visited[i]) begin
               cell_visited[i] = 1'b0;
               cell_walls[i] = 4'hF;
            end
            cell_visited[0] = 1'b1;
            path_cells[0] = '0;
            path_depth = 1;
            e.status = ST_STARTED;
            return 1;
         end
         CMD_READ: begin
            e.status = ST_READ;
            e.from_cell = r.cell_index;
            e.cell_walls = cell_walls[r.cell_index];
            e.done_res = (path_depth == 0);
            return 1;
         end
         CMD_STEP: begin
            if (path_depth == 0) begin
               e.status = ST_FINISHED;
               e.done_res = 1'b1;
               return 1;
            end
            cur = 32'(path_cells[path_depth - 1]);
            x = cur % cols;
            y = cur / cols;
            if (y < rows) begin
               if (y > 0) begin
                  c = cur - cols;
                  if (!cell_visited[c]) begin cand[n] = c; dirn[n] = 0; n++; end
               end
               if (x + 1 < cols) begin
                  c = cur + 1;
                  if (c < CELL_SLOTS && !cell_visited[c]) begin
                     cand[n] = c; dirn[n] = 1; n++;
                  end
               end
               if (y + 1 < rows) begin
                  c = cur + cols;
                  if (c < CELL_SLOTS && !cell_visited[c]) begin
                     cand[n] = c; dirn[n] = 2; n++;
                  end
               end
               if (x > 0) begin
                  c = cur - 1;
                  if (!cell_visited[c]) begin cand[n] = c; dirn[n] = 3; n++; end
               end
            end
            e.from_cell = 12'(cur);
            if (n > 0 && path_depth < CELL_SLOTS) begin
               k = r.random_value % n;
               nxt = cand[k];
               cell_visited[nxt] = 1'b1;
               cell_walls[cur][dirn[k]] = 1'b0;
               cell_walls[nxt][(dirn[k] + 2) % 4] = 1'b0;
               path_cells[path_depth] = 12'(nxt);
               path_depth++;
               e.status = ST_CARVED;
               e.to_cell = 12'(nxt);
               return 1;
            end
            path_depth--;
            e.status = ST_BACKTRACKED;
            e.done_res = (path_depth == 0);
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_payload, 0);
         end else begin
            e = expected_rsps.pop_front();
            status_seen[rsp_payload.status]++;
            if (rsp_payload.status !== e.status)
               report_mismatch("status", rsp_payload.status, e.status);
            if (rsp_payload.from_cell !== e.from_cell)
               report_mismatch("from_cell", rsp_payload.from_cell, e.from_cell);
            if (rsp_payload.to_cell !== e.to_cell)
               report_mismatch("to_cell", rsp_payload.to_cell, e.to_cell);
            if (rsp_payload.cell_walls !== e.cell_walls)
               report_mismatch("cell_walls", rsp_payload.cell_walls, e.cell_walls);
            if (rsp_payload.done_res !== e.done_res)
               report_mismatch("done_res", rsp_payload.done_res, e.done_res);
         end
      end
   end

   // start may stay high from the previous transaction when there is no gap
   task automatic send_item(input logic [1:0] cmd, input logic [15:0] rnd,
                            input logic [11:0] idx);
      int gap;
      req_type r;
      rsp_type e;
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (gap > 0 || !start) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.cmd = cmd;
      r.random_value = rnd;
      r.cell_index = idx;
      start <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
      if (predict_command(r, e)) expected_rsps.insert(expected_rsps.size(), e);
      items_sent++;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      // an ignored command may still be in flight
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [6:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_COLUMNS) columns_reg = value;
      else rows_reg = value;
   endtask

   task automatic test_before_start();
      send_item(CMD_STEP, 16'hFFFF, 12'hFFF);
      send_item(CMD_READ, 16'h0000, 12'h000);
      send_item(CMD_READ, 16'hFFFF, 12'hFFF);
      send_item(CMD_IGNORED, 16'hA5A5, 12'hA5A);
      send_item(CMD_STEP, 16'h0000, 12'h000);
   endtask

   task automatic test_one_cell_grid();
      write_csr(CSR_COLUMNS, 7'd0);
      write_csr(CSR_ROWS, 7'd1);
      send_item(CMD_START, 16'h0000, 12'h000);
      send_item(CMD_STEP, 16'h1234, 12'h000);
      send_item(CMD_STEP, 16'h1234, 12'h000);
      send_item(CMD_READ, 16'h0000, 12'h000);
   endtask

   task automatic test_saturated_grid();
      write_csr(CSR_COLUMNS, 7'd127);
      write_csr(CSR_ROWS, 7'd65);
      send_item(CMD_START, 16'h0000, 12'h000);
      send_item(CMD_STEP, 16'h0000, 12'h000);
      send_item(CMD_STEP, 16'hFFFF, 12'h000);
      send_item(CMD_STEP, 16'h5555, 12'h555);
      send_item(CMD_READ, 16'h0000, 12'h000);
      send_item(CMD_READ, 16'h0000, 12'hFFF);
   endtask

   task automatic test_grid_shrink();
      write_csr(CSR_COLUMNS, 7'd11);
      write_csr(CSR_ROWS, 7'd8);
      send_item(CMD_START, 16'h0000, 12'h000);
      repeat (5) send_item(CMD_STEP, 16'($urandom), 12'h000);
      // current cell now lies outside the grid and gets popped
      write_csr(CSR_COLUMNS, 7'd1);
      write_csr(CSR_ROWS, 7'd1);
      repeat (7) send_item(CMD_STEP, 16'($urandom), 12'h000);
   endtask

   task automatic test_random_mazes();
      logic [6:0] col_set [10] = '{7'd2, 7'd64, 7'd3, 7'd0, 7'd5, 7'd1, 7'd9, 7'd4, 7'd100, 7'd6};
      logic [6:0] row_set [10] = '{7'd2, 7'd1, 7'd64, 7'd3, 7'd0, 7'd6, 7'd2, 7'd127, 7'd4, 7'd5};
      int pick;
      for (int ph = 0; ph < 10; ph++) begin
         write_csr(CSR_COLUMNS, (ph % 3 == 2) ? 7'($urandom) : col_set[ph]);
         write_csr(CSR_ROWS, (ph % 3 == 1) ? 7'($urandom_range(1, 8)) : row_set[ph]);
         no_idle = (ph % 4 == 1);
         send_item(CMD_START, 16'($urandom), 12'($urandom));
         repeat (58) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) send_item(CMD_STEP, 16'($urandom), 12'($urandom));
            else if (pick < 94) send_item(CMD_READ, 16'($urandom), 12'($urandom));
            else if (pick < 98) send_item(CMD_IGNORED, 16'($urandom), 12'($urandom));
            else send_item(CMD_START, 16'($urandom), 12'($urandom));
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_before_start();
      test_one_cell_grid();
      test_saturated_grid();
      test_grid_shrink();
      test_random_mazes();
      wait_idle();
      $display("%0d commands sent over directed and random grids", items_sent);
      $display("carved %0d, backtracked %0d, finished %0d, read %0d, started %0d",
               status_seen[ST_CARVED], status_seen[ST_BACKTRACKED],
               status_seen[ST_FINISHED], status_seen[ST_READ], status_seen[ST_STARTED]);
      if (fail_count == 0) begin
         $display("maze_backtracker_generator_top_test OK");
      end else begin
         $display("maze_backtracker_generator_top_test NOT OK");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("maze_backtracker_generator_top_test NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
hdl/mbg_pkg.sv
hdl/mbg_ram.sv
hdl/mbg_div.sv
hdl/mbg_ctrl.sv
hdl/mbg_dp.sv
hdl/maze_backtracker_generator_top.sv
dv/maze_backtracker_generator_top_test.sv
